// ===== hw/rtl/pbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared widths, register indexes and mode codes for the PCM byte unpacker.
// ----------------------------------------------------------------------------
package pbs_pkg;

   localparam int ByteW   = 8;
   localparam int SampleW = 17;
   localparam int ReqW    = 8;
   localparam int RspW    = 40;
   localparam int CsrIdxW = 2;
   localparam int CsrDatW = 2;
   localparam int PhaseW  = 3;

   typedef logic [CsrIdxW-1:0] csr_idx_type;

   localparam csr_idx_type RegSampleWidth = 2'd0;
   localparam csr_idx_type RegChannelMode = 2'd1;
   localparam csr_idx_type RegBigEndian   = 2'd2;

   typedef logic [1:0] chan_mode_type;

   localparam chan_mode_type ChanMono   = 2'd0;
   localparam chan_mode_type ChanStereo = 2'd1;
   localparam chan_mode_type ChanQuad   = 2'd2;

   typedef logic signed [SampleW-1:0] sample_type;

   localparam sample_type SampleMin = -17'sd32768;
   localparam sample_type SampleMax = 17'sd32768;

endpackage

// ===== hw/rtl/pcm_bytes_to_stereo_samples.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_bytes_to_stereo_samples
// Unpacks interleaved 8/16-bit PCM bytes into Q2.15 left/right frames,
// with mono duplication and quad-to-stereo saturating downmix.
// ----------------------------------------------------------------------------
// A frame's last byte enters the byte register, then its frame the frame register.
// Throughput: one byte per cycle; the byte register and the frame register
// both advance whenever the frame register is empty or being taken.
// Reset: synchronous, active high; clears phase, partials and valids, and
// loads 16-bit, stereo, little endian.
module pcm_bytes_to_stereo_samples (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [pbs_pkg::ReqW-1:0]    req_tdata,   // [7:0] data_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [pbs_pkg::RspW-1:0]    rsp_tdata,   // [16:0] left_sample,
                                                    // [33:17] right_sample,
                                                    // [39:34] zero
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [pbs_pkg::CsrIdxW-1:0] csr_index,
   input  logic [pbs_pkg::CsrDatW-1:0] csr_wdata
);
   import pbs_pkg::*;

   function automatic sample_type sat_q15(input logic signed [SampleW:0] v);
      sample_type r;
      if (v < 18'sd0 - 18'sd32768) r = SampleMin;
      else if (v > 18'sd32768) r = SampleMax;
      else r = v[SampleW-1:0];
      return r;
   endfunction

   logic                 width_ff, width_in;
   chan_mode_type        chan_ff, chan_in;
   logic                 big_ff, big_in;

   logic                 s1_valid_ff, s1_valid_in;
   logic [ByteW-1:0]     s1_byte_ff, s1_byte_in;

   logic [PhaseW-1:0]    phase_ff, phase_in;
   logic [ByteW-1:0]     held_ff, held_in;
   sample_type           lpart_ff, lpart_in;
   sample_type           rpart_ff, rpart_in;

   logic                 out_valid_ff, out_valid_in;
   sample_type           out_left_ff, out_left_in;
   sample_type           out_right_ff, out_right_in;

   logic                 s1_go;
   logic                 emit;
   logic [PhaseW:0]      frame_bytes;
   logic [2:0]           chans;
   logic [PhaseW-1:0]    ph;
   logic [1:0]           ch;
   logic [15:0]          raw;
   sample_type           smp;

   assign csr_ready  = 1'b1;
   assign s1_go      = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;

   always_comb begin
      width_in = width_ff;
      chan_in  = chan_ff;
      big_in   = big_ff;
      if (csr_valid) begin
         case (csr_index)
            RegSampleWidth: width_in = csr_wdata[0];
            RegChannelMode: chan_in  = csr_wdata;
            RegBigEndian:   big_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      if (s1_go) s1_valid_in = 1'b0;
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_tdata[ByteW-1:0];
      end
   end

   always_comb begin
      if (chan_ff[1]) chans = 3'd4;
      else if (chan_ff == ChanStereo) chans = 3'd2;
      else chans = 3'd1;
      frame_bytes = width_ff ? {chans, 1'b0} : {1'b0, chans};
      ph = ({1'b0, phase_ff} >= frame_bytes) ? '0 : phase_ff;
      raw = big_ff ? {held_ff, s1_byte_ff} : {s1_byte_ff, held_ff};
      if (width_ff) begin
         smp = {raw[15], raw};
         ch  = ph[2:1];
      end else begin
         smp = {{2{~s1_byte_ff[7]}}, s1_byte_ff[6:0], 8'h00};
         ch  = ph[1:0];
      end

      phase_in     = ph + 3'd1;
      held_in      = held_ff;
      lpart_in     = lpart_ff;
      rpart_in     = rpart_ff;
      emit         = 1'b0;
      out_left_in  = out_left_ff;
      out_right_in = out_right_ff;

      if (width_ff && !ph[0]) begin
         held_in = s1_byte_ff;
      end else if (chans == 3'd1) begin
         phase_in     = '0;
         emit         = 1'b1;
         out_left_in  = smp;
         out_right_in = smp;
      end else if (chans == 3'd2) begin
         if (ch == 2'd0) begin
            lpart_in = smp;
         end else begin
            phase_in     = '0;
            emit         = 1'b1;
            out_left_in  = lpart_ff;
            out_right_in = smp;
         end
      end else begin
         case (ch)
            2'd0: lpart_in = smp;
            2'd1: rpart_in = smp;
            2'd2: lpart_in = sat_q15({lpart_ff[SampleW-1], lpart_ff}
                                     + {smp[SampleW-1], smp});
            default: begin
               rpart_in     = sat_q15({rpart_ff[SampleW-1], rpart_ff}
                                      + {smp[SampleW-1], smp});
               phase_in     = '0;
               emit         = 1'b1;
               out_left_in  = lpart_ff;
               out_right_in = rpart_in;
            end
         endcase
      end

      if (!s1_go) begin
         phase_in     = phase_ff;
         held_in      = held_ff;
         lpart_in     = lpart_ff;
         rpart_in     = rpart_ff;
         out_left_in  = out_left_ff;
         out_right_in = out_right_ff;
      end

      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_tready) out_valid_in = 1'b0;
      if (s1_go && emit) out_valid_in = 1'b1;
      if (!(s1_go && emit)) begin
         out_left_in  = out_left_ff;
         out_right_in = out_right_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= 1'b1;
         chan_ff      <= ChanStereo;
         big_ff       <= 1'b0;
         s1_valid_ff  <= 1'b0;
         phase_ff     <= '0;
         held_ff      <= '0;
         lpart_ff     <= '0;
         rpart_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         chan_ff      <= chan_in;
         big_ff       <= big_in;
         s1_valid_ff  <= s1_valid_in;
         phase_ff     <= phase_in;
         held_ff      <= held_in;
         lpart_ff     <= lpart_in;
         rpart_ff     <= rpart_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff   <= s1_byte_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspW - 2 * SampleW){1'b0}}, out_right_ff, out_left_ff};

endmodule

// ===== hw/rtl/pbs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbs_checker
// Port-level checks for the PCM byte unpacker, bound to the top level.
// ----------------------------------------------------------------------------
module pbs_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [pbs_pkg::RspW-1:0] rsp_tdata
);
   import pbs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RspW-1:2*SampleW] == '0)
      else $error("rsp pad bits set");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(!rsp_tdata[16] && rsp_tdata[15] && rsp_tdata[14:0] != 15'd0)
                  && !(!rsp_tdata[33] && rsp_tdata[32] && rsp_tdata[31:17] != 15'd0))
      else $error("sample above +1.0");

endmodule

bind pcm_bytes_to_stereo_samples pbs_checker u_pbs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pcm_bytes_to_stereo_samples. Bytes go in on req,
// a local unpacker tracks phase, held byte and partial sums to predict each
// left/right frame, and every rsp word is checked in order. Directed cases
// cover extremes, saturation and format changes mid-frame. Random traffic
// then runs under changing formats and sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module tb;
   import pbs_pkg::*;

   localparam int SettleCycles = 4;
   localparam int StallLimit   = 4000;
   localparam csr_idx_type RegSpare = 2'd3;

   typedef struct {
      sample_type left;
      sample_type right;
   } stereo_frame_type;

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqW-1:0]     req_tdata  = '0;   // [7:0] data_byte
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspW-1:0]     rsp_tdata;         // [16:0] left, [33:17] right
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index  = '0;
   logic [CsrDatW-1:0]  csr_wdata  = '0;

   // unpacker state and registers
   logic               wide_mode;
   chan_mode_type      chan_mode;
   logic               high_first;
   logic [PhaseW-1:0]  phase;
   logic [ByteW-1:0]   held;
   sample_type         left_acc;
   sample_type         right_acc;

   stereo_frame_type frames_due[$];
   int mismatch_count = 0;
   int send_idle_pct  = 0;
   int stall_pct      = 0;
   int hold_cycles    = 0;
   int quiet_cycles   = 0;

   pcm_bytes_to_stereo_samples DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic sample_type clamp_q15(input int v);
      if (v < -32768) return SampleMin;
      if (v > 32768) return SampleMax;
      return sample_type'(v);
   endfunction

   task automatic clear_unpacker();
      wide_mode  = 1'b1;
      chan_mode  = ChanStereo;
      high_first = 1'b0;
      phase      = '0;
      held       = '0;
      left_acc   = '0;
      right_acc  = '0;
   endtask

   task automatic unpack_byte(input logic [ByteW-1:0] b);
      int unsigned chans;
      int unsigned frame_bytes;
      int unsigned ch;
      logic [15:0] raw;
      sample_type  s;
      chans       = chan_mode[1] ? 4 : (chan_mode == ChanStereo ? 2 : 1);
      frame_bytes = chans * (wide_mode ? 2 : 1);
      if (phase >= frame_bytes) phase = '0;
      if (wide_mode) begin
         if (!phase[0]) begin
            held  = b;
            phase = phase + 1'b1;
            return;
         end
         raw = high_first ? {held, b} : {b, held};
         s   = {raw[15], raw};
         ch  = phase >> 1;
      end else begin
         s  = sample_type'((int'(b) - 128) * 256);
         ch = phase;
      end
      if (chans == 1) begin
         phase = '0;
         frames_due.push_back('{s, s});
         return;
      end
      if (chans == 2) begin
         if (ch == 0) begin
            left_acc = s;
            phase    = phase + 1'b1;
         end else begin
            phase = '0;
            frames_due.push_back('{left_acc, s});
         end
         return;
      end
      case (ch)
         0: left_acc  = s;
         1: right_acc = s;
         2: left_acc  = clamp_q15(int'(left_acc) + int'(s));
         default: begin
            right_acc = clamp_q15(int'(right_acc) + int'(s));
            phase     = '0;
            frames_due.push_back('{left_acc, right_acc});
            return;
         end
      endcase
      phase = phase + 1'b1;
   endtask

   // result checker and receiver ready
   always @(posedge clock) begin
      stereo_frame_type due;
      sample_type    got_left;
      sample_type    got_right;
      if (rsp_tvalid && rsp_tready) begin
         got_left  = sample_type'(rsp_tdata[16:0]);
         got_right = sample_type'(rsp_tdata[33:17]);
         if (frames_due.size() == 0) begin
            $error("unexpected frame: left %0d right %0d", got_left, got_right);
            mismatch_count++;
         end else begin
            due = frames_due.pop_front();
            if (got_left !== due.left) begin
               $error("left_sample: expected %0d, got %0d", due.left, got_left);
               mismatch_count++;
            end
            if (got_right !== due.right) begin
               $error("right_sample: expected %0d, got %0d", due.right, got_right);
               mismatch_count++;
            end
         end
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_byte(input logic [ByteW-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      unpack_byte(b);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CsrDatW-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         RegSampleWidth: wide_mode  = val[0];
         RegChannelMode: chan_mode  = val;
         RegBigEndian:   high_first = val[0];
         default: ;
      endcase
   endtask

   task automatic set_format(input logic [1:0] width_val, input logic [1:0] chan_val,
                             input logic [1:0] endian_val);
      drain();
      write_reg(RegSampleWidth, width_val);
      write_reg(RegChannelMode, chan_val);
      write_reg(RegBigEndian, endian_val);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [ByteW-1:0] pick_byte();
      logic [ByteW-1:0] corner[4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};
      if ($urandom_range(3) == 0) return corner[2'($urandom_range(3))];
      return ByteW'($urandom_range(255));
   endfunction

   task automatic test_reset_format();
      send_byte(8'h00);
      send_byte(8'h80);
      send_byte(8'hFF);
      send_byte(8'h7F);
   endtask

   task automatic test_byte_mono();
      set_format(2'd0, ChanMono, 2'd0);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h80);
   endtask

   task automatic test_quad_saturation();
      set_format(2'd0, ChanQuad, 2'd0);
      repeat (4) send_byte(8'h00);
      repeat (4) send_byte(8'hFF);
      // mode 3 folds as quad
      set_format(2'd1, 2'd3, 2'd1);
      repeat (2) begin
         send_byte(8'h80);
         send_byte(8'h00);
         send_byte(8'h7F);
         send_byte(8'hFF);
      end
   endtask

   task automatic test_format_change();
      set_format(2'd1, ChanStereo, 2'd0);
      send_byte(8'h12);
      send_byte(8'h34);
      send_byte(8'h56);
      // phase now past a one-byte frame: restarts
      set_format(2'd0, ChanMono, 2'd0);
      send_byte(8'h7F);
      set_format(2'd0, ChanQuad, 2'd0);
      send_byte(8'h40);
      send_byte(8'hC0);
      // mid-frame switch keeps phase and partials
      set_format(2'd1, ChanQuad, 2'd1);
      @(posedge clock);
      write_reg(RegSpare, 2'd3);
      csr_valid <= 1'b0;
      send_byte(8'h01);
      send_byte(8'h23);
      send_byte(8'hFE);
      send_byte(8'hDC);
      send_byte(8'h80);
      send_byte(8'h01);
   endtask

   task automatic test_backpressure();
      set_format(2'd0, ChanMono, 2'd0);
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_cycles   = 300;
      repeat (60) send_byte(pick_byte());
      drain();
   endtask

   task automatic test_random_traffic();
      int idle_sets[4]  = '{0, 86, 0, 22};
      int stall_sets[4] = '{0, 0, 86, 22};
      int sent;
      int n;
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_sets[p];
         stall_pct     = stall_sets[p];
         sent = 0;
         while (sent < 430) begin
            n = $urandom_range(80, 20);
            set_format(2'($urandom_range(3)), 2'($urandom_range(3)),
                       2'($urandom_range(3)));
            repeat (n) send_byte(pick_byte());
            sent += n;
         end
      end
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   initial begin
      clear_unpacker();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_format();
      test_byte_mono();
      test_quad_saturation();
      test_format_change();
      test_backpressure();
      test_random_traffic();
      drain();
      repeat (2 * SettleCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
